### hdl/halfband_decimator_11_tap_macros.svh
// Assertion macros shared by the checkers of the half-band decimator.
`ifndef HALFBAND_DECIMATOR_11_TAP_MACROS_SVH
`define HALFBAND_DECIMATOR_11_TAP_MACROS_SVH

// Clocked property, switched off while reset is asserted.
`define HBD_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that must also hold during reset.
`define HBD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/hbd_pkg.sv
package hbd_pkg;

	localparam int SAMPLE_WIDTH_DEF = 16;
	localparam int COEF_WIDTH_DEF   = 18;

	// Seven distinct weights, ten past samples kept.
	localparam int NUM_COEFS   = 7;
	localparam int IDX_W       = 3;
	localparam int DELAY_DEPTH = 10;

	// Delay line slot feeding each weight except the newest one.
	// Slot 0 is the oldest sample x[n-10].
	localparam int TAP_POS [NUM_COEFS-1] = '{0, 2, 4, 5, 6, 8};

	// Configuration register indexes.
	typedef enum logic [IDX_W-1:0] {
		COEF_OUTER_OLD  = 3'd0,
		COEF_SECOND_OLD = 3'd1,
		COEF_THIRD_OLD  = 3'd2,
		COEF_CENTER     = 3'd3,
		COEF_THIRD_NEW  = 3'd4,
		COEF_SECOND_NEW = 3'd5,
		COEF_OUTER_NEW  = 3'd6
	} coef_idx_t;

endpackage

### hdl/hbd_if.sv
// Input sample channel.
interface hbd_in_if #(parameter int SAMPLE_WIDTH = 16);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample_re;
	logic signed [SAMPLE_WIDTH-1:0] sample_im;

	modport source (output valid, output sample_re, output sample_im, input ready);
	modport sink (input valid, input sample_re, input sample_im, output ready);
endinterface

// Output result channel.
interface hbd_out_if #(parameter int SAMPLE_WIDTH = 16);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] out_re;
	logic signed [SAMPLE_WIDTH-1:0] out_im;

	modport source (output valid, output out_re, output out_im, input ready);
	modport sink (input valid, input out_re, input out_im, output ready);
endinterface

### hdl/halfband_decimator_11_tap.sv
// 11-tap half-band FIR, decimate by two, complex I/Q.
//
// sample_in takes one complex word (sample_re, sample_im) per clock on
// valid/ready. The first word after reset and every second word after it
// each give one filtered word on result_out (out_re, out_im); the others
// only enter the delay line. The seven weights are written through cfg_we /
// cfg_index / cfg_data; the user must write them only while the block is
// idle; the block does not enforce it. Unused indexes are dropped.
//
// A result word passes four registered stages, starting at the edge that
// accepts its input word (window capture, multiply, partial sums, final add
// with round and saturate). Throughput: one input word per clock while
// sample_in.ready is high, one output word per two input words.
//
// Reset clears the delay line to zero, sets the phase so the next word
// emits, and restores the weights (center one half, others zero). When the
// receiver stalls, the result is held and up to three more results queue in
// the stages; sample_in.ready drops only once all of them are occupied.
module halfband_decimator_11_tap
	import hbd_pkg::*;
#(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
	parameter int COEF_WIDTH   = COEF_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [IDX_W-1:0]      cfg_index,
	input  logic [COEF_WIDTH-1:0] cfg_data,
	hbd_in_if.sink                sample_in,
	hbd_out_if.source             result_out
);

	logic signed [COEF_WIDTH-1:0]   coef [NUM_COEFS];
	logic signed [SAMPLE_WIDTH-1:0] tap_re_s1 [NUM_COEFS];
	logic signed [SAMPLE_WIDTH-1:0] tap_im_s1 [NUM_COEFS];
	logic                           valid_s1;
	logic                           free_s1;

	hbd_coef_regs #(.COEF_WIDTH(COEF_WIDTH)) u_coef (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.coef      (coef)
	);

	hbd_taps #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_taps (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_in (sample_in),
		.free_s1   (free_s1),
		.valid_s1  (valid_s1),
		.tap_re_s1 (tap_re_s1),
		.tap_im_s1 (tap_im_s1)
	);

	hbd_mac #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .COEF_WIDTH(COEF_WIDTH)) u_mac (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s1   (valid_s1),
		.tap_re_s1  (tap_re_s1),
		.tap_im_s1  (tap_im_s1),
		.coef       (coef),
		.free_s1    (free_s1),
		.result_out (result_out)
	);

endmodule

### hdl/hbd_coef_regs.sv
module hbd_coef_regs
	import hbd_pkg::*;
#(
	parameter int COEF_WIDTH = COEF_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [IDX_W-1:0]             cfg_index,
	input  logic [COEF_WIDTH-1:0]        cfg_data,
	output logic signed [COEF_WIDTH-1:0] coef [NUM_COEFS]
);

	// Center weight resets to one half.
	localparam logic signed [COEF_WIDTH-1:0] CENTER_RST = COEF_WIDTH'(1) << (COEF_WIDTH-2);

	logic signed [COEF_WIDTH-1:0] coef_q [NUM_COEFS];

	// Write one weight; drop writes to unused indexes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_COEFS; i++) begin
				coef_q[i] <= (i == int'(COEF_CENTER)) ? CENTER_RST : '0;
			end
		end else if (cfg_we) begin
			unique case (coef_idx_t'(cfg_index))
				COEF_OUTER_OLD:  coef_q[COEF_OUTER_OLD]  <= cfg_data;
				COEF_SECOND_OLD: coef_q[COEF_SECOND_OLD] <= cfg_data;
				COEF_THIRD_OLD:  coef_q[COEF_THIRD_OLD]  <= cfg_data;
				COEF_CENTER:     coef_q[COEF_CENTER]     <= cfg_data;
				COEF_THIRD_NEW:  coef_q[COEF_THIRD_NEW]  <= cfg_data;
				COEF_SECOND_NEW: coef_q[COEF_SECOND_NEW] <= cfg_data;
				COEF_OUTER_NEW:  coef_q[COEF_OUTER_NEW]  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign coef = coef_q;

endmodule

### hdl/hbd_taps.sv
module hbd_taps
	import hbd_pkg::*;
#(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	hbd_in_if.sink                         sample_in,
	input  logic                           free_s1,
	output logic                           valid_s1,
	output logic signed [SAMPLE_WIDTH-1:0] tap_re_s1 [NUM_COEFS],
	output logic signed [SAMPLE_WIDTH-1:0] tap_im_s1 [NUM_COEFS]
);

	logic signed [SAMPLE_WIDTH-1:0] dly_re_q [DELAY_DEPTH];
	logic signed [SAMPLE_WIDTH-1:0] dly_im_q [DELAY_DEPTH];
	logic                           phase_q;
	logic                           valid_q;
	logic                           accept;

	assign sample_in.ready = free_s1;
	assign accept          = sample_in.valid && free_s1;

	// Shift every accepted word into the delay line and flip the phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DELAY_DEPTH; i++) begin
				dly_re_q[i] <= '0;
				dly_im_q[i] <= '0;
			end
			phase_q <= 1'b0;
		end else if (accept) begin
			for (int i = 0; i < DELAY_DEPTH-1; i++) begin
				dly_re_q[i] <= dly_re_q[i+1];
				dly_im_q[i] <= dly_im_q[i+1];
			end
			dly_re_q[DELAY_DEPTH-1] <= sample_in.sample_re;
			dly_im_q[DELAY_DEPTH-1] <= sample_in.sample_im;
			phase_q                 <= !phase_q;
		end
	end

	// Launch a filter pass on emitting words only.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free_s1) begin
			valid_q <= accept && !phase_q;
		end
	end

	// Capture the filter window of the emitting word.
	always_ff @(posedge clk) begin
		if (accept && !phase_q) begin
			for (int k = 0; k < NUM_COEFS-1; k++) begin
				tap_re_s1[k] <= dly_re_q[TAP_POS[k]];
				tap_im_s1[k] <= dly_im_q[TAP_POS[k]];
			end
			tap_re_s1[NUM_COEFS-1] <= sample_in.sample_re;
			tap_im_s1[NUM_COEFS-1] <= sample_in.sample_im;
		end
	end

	assign valid_s1 = valid_q;

endmodule

### hdl/hbd_mac.sv
module hbd_mac
	import hbd_pkg::*;
#(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
	parameter int COEF_WIDTH   = COEF_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           valid_s1,
	input  logic signed [SAMPLE_WIDTH-1:0] tap_re_s1 [NUM_COEFS],
	input  logic signed [SAMPLE_WIDTH-1:0] tap_im_s1 [NUM_COEFS],
	input  logic signed [COEF_WIDTH-1:0]   coef [NUM_COEFS],
	output logic                           free_s1,
	hbd_out_if.source                      result_out
);

	localparam int PROD_W = SAMPLE_WIDTH + COEF_WIDTH;
	localparam int ACC_W  = PROD_W + 3;
	localparam int FRAC   = COEF_WIDTH - 1;

	localparam logic signed [ACC_W-1:0] RND  = {{(ACC_W-1){1'b0}}, 1'b1} << (COEF_WIDTH-2);
	localparam logic signed [ACC_W-1:0] MAXV =
		{{(ACC_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] MINV =
		{{(ACC_W-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};

	logic                           valid_s2, valid_s3, valid_s4;
	logic                           free_s2, free_s3, free_s4;
	logic signed [PROD_W-1:0]       prod_re_s2 [NUM_COEFS];
	logic signed [PROD_W-1:0]       prod_im_s2 [NUM_COEFS];
	logic signed [ACC_W-1:0]        part_re_a_s3, part_re_b_s3;
	logic signed [ACC_W-1:0]        part_im_a_s3, part_im_b_s3;
	logic signed [SAMPLE_WIDTH-1:0] out_re_s4, out_im_s4;

	// Shift out the fraction bits and clamp to the sample range.
	function automatic logic signed [SAMPLE_WIDTH-1:0] round_sat(
		input logic signed [ACC_W-1:0] acc
	);
		logic signed [ACC_W-1:0] shf;
		shf = acc >>> FRAC;
		if (shf > MAXV) begin
			return MAXV[SAMPLE_WIDTH-1:0];
		end else if (shf < MINV) begin
			return MINV[SAMPLE_WIDTH-1:0];
		end
		return shf[SAMPLE_WIDTH-1:0];
	endfunction

	// A stage takes a new word when it is empty or its word moves on.
	assign free_s4 = !valid_s4 || result_out.ready;
	assign free_s3 = !valid_s3 || free_s4;
	assign free_s2 = !valid_s2 || free_s3;
	assign free_s1 = !valid_s1 || free_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (free_s2) begin
				valid_s2 <= valid_s1;
			end
			if (free_s3) begin
				valid_s3 <= valid_s2;
			end
			if (free_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	// Multiply each tap by its weight.
	always_ff @(posedge clk) begin
		if (free_s2 && valid_s1) begin
			for (int k = 0; k < NUM_COEFS; k++) begin
				prod_re_s2[k] <= tap_re_s1[k] * coef[k];
				prod_im_s2[k] <= tap_im_s1[k] * coef[k];
			end
		end
	end

	// Form two partial sums; the rounding offset rides on the second.
	always_ff @(posedge clk) begin
		if (free_s3 && valid_s2) begin
			part_re_a_s3 <= ACC_W'(prod_re_s2[0]) + ACC_W'(prod_re_s2[1])
				+ ACC_W'(prod_re_s2[2]) + ACC_W'(prod_re_s2[3]);
			part_re_b_s3 <= ACC_W'(prod_re_s2[4]) + ACC_W'(prod_re_s2[5])
				+ ACC_W'(prod_re_s2[6]) + RND;
			part_im_a_s3 <= ACC_W'(prod_im_s2[0]) + ACC_W'(prod_im_s2[1])
				+ ACC_W'(prod_im_s2[2]) + ACC_W'(prod_im_s2[3]);
			part_im_b_s3 <= ACC_W'(prod_im_s2[4]) + ACC_W'(prod_im_s2[5])
				+ ACC_W'(prod_im_s2[6]) + RND;
		end
	end

	// Final add, round and saturate into the output register.
	always_ff @(posedge clk) begin
		if (free_s4 && valid_s3) begin
			out_re_s4 <= round_sat(part_re_a_s3 + part_re_b_s3);
			out_im_s4 <= round_sat(part_im_a_s3 + part_im_b_s3);
		end
	end

	assign result_out.valid  = valid_s4;
	assign result_out.out_re = out_re_s4;
	assign result_out.out_im = out_im_s4;

endmodule

### hdl/hbd_checker.sv
`include "halfband_decimator_11_tap_macros.svh"

module hbd_checker #(
	parameter int SAMPLE_WIDTH = 16
) (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic [SAMPLE_WIDTH-1:0] out_re,
	input logic [SAMPLE_WIDTH-1:0] out_im
);

	// A stalled result word stays offered.
	`HBD_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid, "result dropped while stalled")

	// A stalled result word keeps its value.
	`HBD_ASSERT(a_out_stable, clk, arst_n, out_valid && !out_ready |=> $stable(out_re) && $stable(out_im), "result changed while stalled")

	// With the output slot free or draining, input is never blocked.
	`HBD_ASSERT(a_in_ready, clk, arst_n, !out_valid || out_ready |-> in_ready, "input blocked with free output slot")

	// Reset seen at an edge leaves the output register empty by the next edge.
	`HBD_ASSERT_ALWAYS(a_rst_empty, clk, !arst_n |=> !out_valid, "result offered after reset")

endmodule

bind halfband_decimator_11_tap hbd_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_hbd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (sample_in.ready),
	.out_valid (result_out.valid),
	.out_ready (result_out.ready),
	.out_re    (result_out.out_re),
	.out_im    (result_out.out_im)
);
